// ----- rtl/hash_bucket_slot_store_macros.svh -----
// assertion macros for the bucket rtl, used by hbss_back
`ifndef HASH_BUCKET_SLOT_STORE_MACROS_SVH
`define HASH_BUCKET_SLOT_STORE_MACROS_SVH

`ifndef ASSERT_OFF
`define HBSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define HBSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HBSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HBSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/hbss_pkg.sv -----
`default_nettype none

package hbss_pkg;

    localparam int FIELD_W     = 32;
    localparam int OUT_COUNT_W = 6;
    localparam int RESULT_CAP  = 32;
    localparam int SENT_W      = 5;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_DUP  = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_MISS = 2'd3;

    typedef logic [SENT_W-1:0] sent_t;

    // update request from the sequencer to the slot cells
    typedef struct packed {
        logic set_slot;
        logic drop_slot;
        logic wipe;
    } slot_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/hash_bucket_slot_store.sv -----
// channel   direction  ports                                        handshake
// s_        in         operation, key, value                        s_valid / s_ready
// m_        out        status, found_value, last, entry_count,      m_valid / m_ready
//                      is_full, is_empty
//
// insert, remove and clear each do a queue pop with slot compare, then update and result;
// a lookup does a pop with compare, then one beat per matching slot, or one miss beat
// the back-end sequencer sets the pace; all slots are compared at once in their cells
// aresetn low for one cycle empties the bucket, the queue and the output register
// the two-entry queue takes input beats until it is full while m_ready stalls the back end
`default_nettype none

module hash_bucket_slot_store #(
    parameter int SLOTS      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_operation,
    input  wire logic [hbss_pkg::FIELD_W-1:0]     s_key,
    input  wire logic [hbss_pkg::FIELD_W-1:0]     s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [hbss_pkg::FIELD_W-1:0]          m_found_value,
    output logic                                  m_last,
    output logic [hbss_pkg::OUT_COUNT_W-1:0]      m_entry_count,
    output logic                                  m_is_full,
    output logic                                  m_is_empty
);
    import hbss_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic                  q_valid, q_pop;
    op_t                   q_op;
    logic [KEY_BITS-1:0]   q_key, wr_key;
    logic [VALUE_BITS-1:0] q_value, wr_value, rd_value;
    logic [SLOTS-1:0]      key_hit, pair_hit, valid_vec;
    logic [CNT_W-1:0]      count;
    slot_cmd_t             cmd;
    logic [IDX_W-1:0]      cmd_index, rd_index;
    status_t               status;

    hbss_front #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (aclk),
        .rstn        (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (op_t'(s_operation)),
        .s_key       (s_key),
        .s_value     (s_value),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_op        (q_op),
        .q_key       (q_key),
        .q_value     (q_value)
    );

    hbss_slots #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_slots (
        .clk       (aclk),
        .rstn      (aresetn),
        .cmp_key   (q_key),
        .cmp_value (q_value),
        .key_hit   (key_hit),
        .pair_hit  (pair_hit),
        .valid_vec (valid_vec),
        .count     (count),
        .cmd       (cmd),
        .cmd_index (cmd_index),
        .wr_key    (wr_key),
        .wr_value  (wr_value),
        .rd_index  (rd_index),
        .rd_value  (rd_value)
    );

    hbss_back #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk           (aclk),
        .rstn          (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_op          (q_op),
        .q_key         (q_key),
        .q_value       (q_value),
        .key_hit       (key_hit),
        .pair_hit      (pair_hit),
        .valid_vec     (valid_vec),
        .count         (count),
        .cmd           (cmd),
        .cmd_index     (cmd_index),
        .wr_key        (wr_key),
        .wr_value      (wr_value),
        .rd_index      (rd_index),
        .rd_value      (rd_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (status),
        .m_found_value (m_found_value),
        .m_last        (m_last),
        .m_entry_count (m_entry_count),
        .m_is_full     (m_is_full),
        .m_is_empty    (m_is_empty)
    );

    assign m_status = status;

endmodule

`default_nettype wire

// ----- rtl/hbss_front.sv -----
`default_nettype none

module hbss_front #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rstn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire hbss_pkg::op_t               s_operation,
    input  wire logic [hbss_pkg::FIELD_W-1:0] s_key,
    input  wire logic [hbss_pkg::FIELD_W-1:0] s_value,
    output logic                             q_valid,
    input  wire logic                        q_pop,
    output hbss_pkg::op_t                    q_op,
    output logic [KEY_BITS-1:0]              q_key,
    output logic [VALUE_BITS-1:0]            q_value
);
    import hbss_pkg::*;

    logic [1:0]            fill_reg, fill_next;
    logic                  wr_ptr_reg, rd_ptr_reg;
    op_t                   op_mem_reg  [2];
    logic [KEY_BITS-1:0]   key_mem_reg [2];
    logic [VALUE_BITS-1:0] val_mem_reg [2];
    logic                  push;
    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] val_in;

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);

    // keys and values enter at their stored widths
    assign key_in = KEY_BITS'(s_key);
    assign val_in = VALUE_BITS'(s_value);

    always_comb begin
        fill_next = fill_reg;
        if (push && !q_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (q_pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            op_mem_reg[wr_ptr_reg]  <= s_operation;
            key_mem_reg[wr_ptr_reg] <= key_in;
            val_mem_reg[wr_ptr_reg] <= val_in;
        end
    end

    assign q_op    = op_mem_reg[rd_ptr_reg];
    assign q_key   = key_mem_reg[rd_ptr_reg];
    assign q_value = val_mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/hbss_slots.sv -----
`default_nettype none

module hbss_slots #(
    parameter int SLOTS      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W     = $clog2(SLOTS + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rstn,
    input  wire logic [KEY_BITS-1:0]   cmp_key,
    input  wire logic [VALUE_BITS-1:0] cmp_value,
    output logic [SLOTS-1:0]           key_hit,
    output logic [SLOTS-1:0]           pair_hit,
    output logic [SLOTS-1:0]           valid_vec,
    output logic [CNT_W-1:0]           count,
    input  wire hbss_pkg::slot_cmd_t   cmd,
    input  wire logic [IDX_W-1:0]      cmd_index,
    input  wire logic [KEY_BITS-1:0]   wr_key,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    input  wire logic [IDX_W-1:0]      rd_index,
    output logic [VALUE_BITS-1:0]      rd_value
);
    import hbss_pkg::*;

    logic [KEY_BITS-1:0]   key_reg   [SLOTS];
    logic [VALUE_BITS-1:0] value_reg [SLOTS];
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.wipe) begin
            valid_next = '0;
            count_next = '0;
        end else if (cmd.set_slot) begin
            valid_next[cmd_index] = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.drop_slot) begin
            valid_next[cmd_index] = 1'b0;
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.set_slot) begin
            key_reg[cmd_index]   <= wr_key;
            value_reg[cmd_index] <= wr_value;
        end
    end

    // one comparator pair per slot
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        assign key_hit[i]  = valid_reg[i] && (key_reg[i] == cmp_key);
        assign pair_hit[i] = key_hit[i] && (value_reg[i] == cmp_value);
    end

    assign valid_vec = valid_reg;
    assign count     = count_reg;
    assign rd_value  = value_reg[rd_index];

endmodule

`default_nettype wire

// ----- rtl/hbss_back.sv -----
`default_nettype none
`include "hash_bucket_slot_store_macros.svh"

module hbss_back #(
    parameter int SLOTS      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W     = $clog2(SLOTS + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rstn,
    input  wire logic                            q_valid,
    output logic                                 q_pop,
    input  wire hbss_pkg::op_t                   q_op,
    input  wire logic [KEY_BITS-1:0]             q_key,
    input  wire logic [VALUE_BITS-1:0]           q_value,
    input  wire logic [SLOTS-1:0]                key_hit,
    input  wire logic [SLOTS-1:0]                pair_hit,
    input  wire logic [SLOTS-1:0]                valid_vec,
    input  wire logic [CNT_W-1:0]                count,
    output hbss_pkg::slot_cmd_t                  cmd,
    output logic [IDX_W-1:0]                     cmd_index,
    output logic [KEY_BITS-1:0]                  wr_key,
    output logic [VALUE_BITS-1:0]                wr_value,
    output logic [IDX_W-1:0]                     rd_index,
    input  wire logic [VALUE_BITS-1:0]           rd_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output hbss_pkg::status_t                    m_status,
    output logic [hbss_pkg::FIELD_W-1:0]         m_found_value,
    output logic                                 m_last,
    output logic [hbss_pkg::OUT_COUNT_W-1:0]     m_entry_count,
    output logic                                 m_is_full,
    output logic                                 m_is_empty
);
    import hbss_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic                  state_reg, state_next;
    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SLOTS-1:0]      hits_reg, hits_next;
    logic [SLOTS-1:0]      pairs_reg;
    sent_t                 sent_reg, sent_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg;
    logic [FIELD_W-1:0]    found_reg;
    logic                  last_reg;
    logic [OUT_COUNT_W-1:0] entry_count_reg;
    logic                  full_reg, empty_reg;

    logic                  out_free, emit_fire;
    logic [SLOTS-1:0]      hits_rest, free_vec;
    logic [IDX_W-1:0]      hit_idx, free_idx, pair_idx;
    status_t               out_status;
    logic [FIELD_W-1:0]    out_found;
    logic                  out_last;
    logic [CNT_W-1:0]      count_after;
    slot_cmd_t             cmd_raw;

    function automatic logic [IDX_W-1:0] lowest_index(input logic [SLOTS-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    assign hits_rest = hits_reg & (hits_reg - SLOTS'(1));
    assign free_vec  = ~valid_vec;
    assign hit_idx   = lowest_index(hits_reg);
    assign free_idx  = lowest_index(free_vec);
    assign pair_idx  = lowest_index(pairs_reg);

    always_comb begin
        out_status  = ST_OK;
        out_found   = '0;
        out_last    = 1'b1;
        count_after = count;
        cmd_raw     = '0;
        cmd_index   = free_idx;
        unique case (op_reg)
            OP_LOOKUP: begin
                if (hits_reg == '0) begin
                    out_status = ST_MISS;
                end else begin
                    out_found = FIELD_W'(rd_value);
                    // the result count is capped, the capped beat closes the item
                    out_last  = (hits_rest == '0) || (sent_reg == sent_t'(RESULT_CAP - 1));
                end
            end
            OP_INSERT: begin
                if (pairs_reg != '0) begin
                    out_status = ST_DUP;
                end else if (free_vec == '0) begin
                    out_status = ST_FULL;
                end else begin
                    cmd_raw.set_slot = 1'b1;
                    count_after      = count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (pairs_reg != '0) begin
                    cmd_raw.drop_slot = 1'b1;
                    cmd_index         = pair_idx;
                    count_after       = count - CNT_W'(1);
                end else begin
                    out_status = ST_MISS;
                end
            end
            OP_CLEAR: begin
                cmd_raw.wipe = 1'b1;
                count_after  = '0;
            end
        endcase
    end

    assign cmd      = emit_fire ? cmd_raw : '0;
    assign wr_key   = key_reg;
    assign wr_value = value_reg;
    assign rd_index = hit_idx;

    always_comb begin
        state_next = state_reg;
        hits_next  = hits_reg;
        sent_next  = sent_reg;
        if (q_pop) begin
            state_next = S_EMIT;
            hits_next  = key_hit;
            sent_next  = '0;
        end else if (emit_fire) begin
            hits_next = hits_rest;
            sent_next = sent_reg + sent_t'(1);
            if (out_last) begin
                state_next = S_IDLE;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            op_reg      <= OP_LOOKUP;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                op_reg <= q_op;
            end
        end
    end

    always_ff @(posedge clk) begin
        hits_reg <= hits_next;
        sent_reg <= sent_next;
        if (q_pop) begin
            key_reg   <= q_key;
            value_reg <= q_value;
            pairs_reg <= pair_hit;
        end
        if (emit_fire) begin
            status_reg      <= out_status;
            found_reg       <= out_found;
            last_reg        <= out_last;
            entry_count_reg <= OUT_COUNT_W'(count_after);
            full_reg        <= (count_after == CNT_W'(SLOTS));
            empty_reg       <= (count_after == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_value = found_reg;
    assign m_last        = last_reg;
    assign m_entry_count = entry_count_reg;
    assign m_is_full     = full_reg;
    assign m_is_empty    = empty_reg;

    `HBSS_ASSERT_IMP(a_hit_has_pending, clk, rstn, emit_fire && (op_reg == OP_LOOKUP) && (out_status == ST_OK), hits_reg != '0, "lookup hit beat without a pending match")
    `HBSS_ASSERT_NXT(a_clear_empties, clk, rstn, emit_fire && (op_reg == OP_CLEAR), count == '0, "bucket not empty after clear")
    `HBSS_ASSERT_NXT(a_insert_grows, clk, rstn, emit_fire && (op_reg == OP_INSERT) && (out_status == ST_OK), count == $past(count) + CNT_W'(1), "insert did not add one slot")
    `HBSS_ASSERT_IMP(a_count_bound, clk, rstn, 1'b1, count <= CNT_W'(SLOTS), "valid count above slot total")

endmodule

`default_nettype wire
